// ===== hdl/dtss_pkg.sv =====
// Shared types, codes and constants for the dual-timer square synth.
// No dependencies; dtss_lowest and the top level refer to this package by scope.
package dtss_pkg;

  // Default values for the top-level parameters.
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int POT_MAX_DEF     = 470000;
  localparam int NOTE_COUNT_DEF  = 128;

  // Fixed field widths.
  localparam int CMD_W       = 3;
  localparam int NOTE_W      = 7;
  localparam int BEND_W      = 14;
  localparam int POT_IN_W    = 19;
  localparam int SCALE_W     = 32;
  localparam int AMP_W       = 15;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  // Reset values.
  localparam logic [SCALE_W-1:0] ASTABLE_SCALE_RST = 32'd1428698;
  localparam logic [SCALE_W-1:0] MONO_SCALE_RST    = 32'd14286979;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST     = 15'd32767;
  localparam int                 POT_A_RST         = 100000;
  localparam int                 POT_M_RST         = 80000;

  // The astable high phase sees the pot plus a fixed series resistance.
  localparam int ASTABLE_EXTRA = 1000;

  // Pitch bend centre and the matching shift.
  localparam logic [BEND_W-1:0] BEND_CENTER = 14'h2000;
  localparam int                BEND_SHIFT  = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_NOTE_ON  = 3'd1,
    CMD_NOTE_OFF = 3'd2,
    CMD_BEND     = 3'd3,
    CMD_LOAD     = 3'd4,
    CMD_SET_POTS = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ASTABLE_SCALE = 2'd0,
    CFG_MONO_SCALE    = 2'd1,
    CFG_AMPLITUDE     = 2'd2
  } cfg_idx_t;

  // Result of the lowest-held-note search.
  typedef struct packed {
    logic              any;
    logic [NOTE_W-1:0] idx;
  } low_t;

endpackage

// ===== hdl/dtss_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dtss_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/dtss_lowest.sv =====
// Two-stage registered search for the lowest set bit of the held-note bitmap.
// Depends on dtss_pkg for the result struct.
module dtss_lowest #(
  parameter int NOTE_COUNT = dtss_pkg::NOTE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic [NOTE_COUNT-1:0] held,
  output dtss_pkg::low_t        low
);

  localparam int GRP  = 16;
  localparam int NGRP = (NOTE_COUNT + GRP - 1) / GRP;
  localparam int GW   = $clog2(GRP);

  logic [NGRP*GRP-1:0] padded;
  logic [NGRP-1:0]     grp_any_nxt;
  logic [NGRP-1:0]     grp_any_r;
  logic [GW-1:0]       grp_idx_nxt [NGRP];
  logic [GW-1:0]       grp_idx_r   [NGRP];
  dtss_pkg::low_t      low_nxt;
  dtss_pkg::low_t      low_r;

  assign padded = (NGRP*GRP)'(held);

  // First stage: each group of sixteen notes finds its own lowest bit.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |padded[g*GRP +: GRP];
      grp_idx_nxt[g] = '0;
      for (int i = GRP - 1; i >= 0; i--) begin
        if (padded[g*GRP + i]) begin
          grp_idx_nxt[g] = GW'(i);
        end
      end
    end
  end

  // Second stage: the lowest group with any bit set wins.
  always_comb begin
    low_nxt.any = |grp_any_r;
    low_nxt.idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        low_nxt.idx = dtss_pkg::NOTE_W'(g*GRP) + dtss_pkg::NOTE_W'(grp_idx_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_idx_r <= grp_idx_nxt;
    low_r     <= low_nxt;
  end

  assign low = low_r;

endmodule

// ===== hdl/dual_timer_square_synth_top.sv =====
// Top level of the dual-timer square synth: control sequencer, timers, note table.
// Depends on dtss_pkg, dtss_ram and dtss_lowest.
//
//   Channel   Direction  Handshake           Payload
//   in_       slave      in_tvalid/in_tready  tdata: note, bend, pot_a, pot_b, gate; tuser: cmd
//   out_      master     out_tvalid/out_tready tdata: sample, level, sounding
//   cfg_      write      cfg_we               cfg_index selects register, cfg_wdata value
//
// A tick item is accepted, then in the tick state both timers advance and the sample is
// placed in the output register. A table load is written as it is accepted. Set pots goes
// straight to the threshold steps, note on first reads its own table entry, and note off
// or bend first search for the lowest held note and return to idle if none is held. The
// note table is read through one registered RAM port, the lowest held note comes from a
// two-stage registered search, and the three thresholds are worked out one after another
// on a single shared 32-bit multiplier. After reset and after every register write the
// thresholds are recomputed before the next item is taken. A waiting result does not block
// input: the next item is accepted while the output register holds, and only a further
// tick waits for it to drain.
module dual_timer_square_synth_top #(
  parameter int COUNT_WIDTH = dtss_pkg::COUNT_WIDTH_DEF,
  parameter int POT_MAX     = dtss_pkg::POT_MAX_DEF,
  parameter int NOTE_COUNT  = dtss_pkg::NOTE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata from bit 0 up: note[6:0], bend[20:7], pot_a[39:21], pot_b[58:40], gate[59]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dtss_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser from bit 0 up: cmd[2:0]
  input  logic [dtss_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata from bit 0 up: sample[15:0], level[16], sounding[17]
  output logic [dtss_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [dtss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtss_pkg::SCALE_W-1:0]         cfg_wdata
);

  localparam int CW      = COUNT_WIDTH;
  localparam int IDX_W   = $clog2(NOTE_COUNT);
  // Pots must hold the clamp limit, the reset values and the astable series resistance.
  localparam int POT_TOP = (POT_MAX > dtss_pkg::POT_A_RST) ? POT_MAX : dtss_pkg::POT_A_RST;
  localparam int POT_W   = $clog2(POT_TOP + dtss_pkg::ASTABLE_EXTRA + 1);
  localparam int PROD_W  = dtss_pkg::SCALE_W + POT_W;
  localparam int HI_W    = (POT_W > CW) ? POT_W : CW;
  localparam int TBL_W   = 2 * POT_W;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_FIND1, S_FIND2, S_RD, S_USE, S_BADD,
    S_MUL0, S_MUL1, S_MUL2, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [dtss_pkg::SCALE_W-1:0] astable_scale_r;
  logic [dtss_pkg::SCALE_W-1:0] mono_scale_r;
  logic [dtss_pkg::AMP_W-1:0]   amplitude_r;
  logic                         recalc_pend_r;

  // Timer state.
  logic [NOTE_COUNT-1:0] held_r;
  logic [POT_W-1:0]      pot_a_r;
  logic [POT_W-1:0]      pot_m_r;
  logic [CW-1:0]         ah_r;
  logic [CW-1:0]         al_r;
  logic [CW-1:0]         mh_r;
  logic [CW:0]           period_r;
  logic [CW-1:0]         ac_r;
  logic [CW-1:0]         mc_r;
  logic                  lvl_r;

  // Captured item and datapath registers.
  dtss_pkg::cmd_t               cmd_r;
  logic [IDX_W-1:0]             note_r;
  logic [dtss_pkg::BEND_W-1:0]  bend_r;
  logic                         gate_r;
  logic [PROD_W-1:0]            prod_r;
  logic [POT_W-1:0]             c_r;

  logic                                 out_tvalid_r;
  logic [dtss_pkg::OUT_TDATA_W-1:0]     out_tdata_r;

  // Input field decode.
  dtss_pkg::cmd_t              in_cmd;
  logic [dtss_pkg::NOTE_W-1:0] in_note;
  logic [dtss_pkg::BEND_W-1:0] in_bend;
  logic [dtss_pkg::POT_IN_W-1:0] in_pa;
  logic [dtss_pkg::POT_IN_W-1:0] in_pb;
  logic                        in_gate;
  logic [POT_W-1:0]            pa_cl;
  logic [POT_W-1:0]            pb_cl;
  logic                        note_ok;
  logic                        in_acc;

  assign in_cmd  = dtss_pkg::cmd_t'(in_tuser);
  assign in_note = in_tdata[6:0];
  assign in_bend = in_tdata[20:7];
  assign in_pa   = in_tdata[39:21];
  assign in_pb   = in_tdata[58:40];
  assign in_gate = in_tdata[59];

  // Pots above the limit are clamped on table load and on a direct set.
  assign pa_cl = (32'(in_pa) > 32'(POT_MAX)) ? POT_W'(POT_MAX) : POT_W'(in_pa);
  assign pb_cl = (32'(in_pb) > 32'(POT_MAX)) ? POT_W'(POT_MAX) : POT_W'(in_pb);
  assign note_ok = (32'(in_note) < 32'(NOTE_COUNT));

  // Ready only when idle and the thresholds match the current registers.
  assign in_tready = (state_r == S_IDLE) && !recalc_pend_r && !cfg_we;
  assign in_acc    = in_tvalid && in_tready;

  // Note table: one entry per note, astable pot in the low half.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [TBL_W-1:0]     ram_rdata;
  logic [POT_W-1:0]     rd_a;
  logic [POT_W-1:0]     rd_b;
  dtss_pkg::low_t       low;

  assign ram_we    = in_acc && (in_cmd == dtss_pkg::CMD_LOAD) && note_ok;
  assign ram_raddr = (cmd_r == dtss_pkg::CMD_NOTE_ON) ? note_r : low.idx[IDX_W-1:0];
  assign rd_a      = ram_rdata[POT_W-1:0];
  assign rd_b      = ram_rdata[TBL_W-1:POT_W];

  dtss_ram #(
    .WIDTH (TBL_W),
    .DEPTH (NOTE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_note[IDX_W-1:0]),
    .wr_data ({pb_cl, pa_cl}),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  dtss_lowest #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_lowest (
    .clk  (clk),
    .held (held_r),
    .low  (low)
  );

  // Bend: the factor multiplies either the centre pot downwards or the span upwards.
  logic                        bend_neg;
  logic [dtss_pkg::BEND_W:0]   factor_w;
  logic [dtss_pkg::BEND_W-1:0] factor;
  logic [POT_W-1:0]            span;
  logic [POT_W-1:0]            bend_shifted;

  assign bend_neg = bend_r < dtss_pkg::BEND_CENTER;
  assign factor_w = bend_neg ?
                    ({1'b0, dtss_pkg::BEND_CENTER} - {1'b0, bend_r}) :
                    ({dtss_pkg::BEND_CENTER, 1'b0} - {1'b0, bend_r});
  assign factor   = factor_w[dtss_pkg::BEND_W-1:0];
  assign span     = POT_W'(POT_MAX) - rd_b;
  assign bend_shifted = prod_r[dtss_pkg::BEND_SHIFT +: POT_W];

  // One shared multiplier; its operands depend on the sequencer step.
  logic [dtss_pkg::SCALE_W-1:0] mul_a;
  logic [POT_W-1:0]             mul_b;
  logic [PROD_W-1:0]            mul_out;

  always_comb begin
    unique case (state_r)
      S_MUL0: begin
        mul_a = astable_scale_r;
        mul_b = pot_a_r + POT_W'(dtss_pkg::ASTABLE_EXTRA);
      end
      S_MUL1: begin
        mul_a = astable_scale_r;
        mul_b = pot_a_r;
      end
      S_MUL2: begin
        mul_a = mono_scale_r;
        mul_b = pot_m_r;
      end
      S_USE: begin
        mul_a = dtss_pkg::SCALE_W'(factor);
        mul_b = bend_neg ? span : rd_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Threshold: the integer part of the Q0.32 product, saturated to the counter width.
  logic [HI_W-1:0] hi_ext;
  logic [CW-1:0]   thr_sat;

  assign hi_ext  = HI_W'(prod_r[PROD_W-1:dtss_pkg::SCALE_W]);
  assign thr_sat = (hi_ext > HI_W'(CNT_MAX)) ? CNT_MAX : CW'(hi_ext);

  // Tick: wrap the astable counter at the end of its period, let the monostable expire,
  // retrigger it when the astable counter sits at the end of its high phase, then count.
  logic [CW-1:0] ac_wrap;
  logic [CW-1:0] mc_mid;
  logic          lvl_nxt;
  logic [CW-1:0] ac_nxt;
  logic [CW-1:0] mc_nxt;
  logic          snd;
  logic [dtss_pkg::SAMPLE_W-1:0] amp_ext;
  logic [dtss_pkg::SAMPLE_W-1:0] sample_nxt;
  logic          out_free;

  always_comb begin
    ac_wrap = ({1'b0, ac_r} >= period_r) ? '0 : ac_r;
    if (mc_r >= mh_r) begin
      if (ac_wrap == ah_r) begin
        mc_mid  = '0;
        lvl_nxt = 1'b1;
      end else begin
        mc_mid  = mc_r;
        lvl_nxt = 1'b0;
      end
    end else begin
      mc_mid  = mc_r;
      lvl_nxt = lvl_r;
    end
    ac_nxt = (ac_wrap == CNT_MAX) ? ac_wrap : ac_wrap + 1'b1;
    mc_nxt = (mc_mid == CNT_MAX) ? mc_mid : mc_mid + 1'b1;
  end

  assign snd        = gate_r || (|held_r);
  assign amp_ext    = {1'b0, amplitude_r};
  assign sample_nxt = !snd ? '0 : (lvl_nxt ? amp_ext : -amp_ext);
  assign out_free   = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      recalc_pend_r   <= 1'b1;
      astable_scale_r <= dtss_pkg::ASTABLE_SCALE_RST;
      mono_scale_r    <= dtss_pkg::MONO_SCALE_RST;
      amplitude_r     <= dtss_pkg::AMPLITUDE_RST;
      held_r          <= '0;
      pot_a_r         <= POT_W'(dtss_pkg::POT_A_RST);
      pot_m_r         <= POT_W'(dtss_pkg::POT_M_RST);
      ac_r            <= '0;
      mc_r            <= '0;
      lvl_r           <= 1'b1;
      out_tvalid_r    <= 1'b0;
    end else begin
      // In the tick state a draining register always lets the tick through, so the tick
      // branch below decides the flag there.
      if (out_tvalid_r && out_tready && state_r != S_TICK) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r  <= in_cmd;
            note_r <= in_note[IDX_W-1:0];
            bend_r <= in_bend;
            gate_r <= in_gate;
            unique case (in_cmd)
              dtss_pkg::CMD_TICK: begin
                state_r <= S_TICK;
              end
              dtss_pkg::CMD_NOTE_ON: begin
                if (note_ok) begin
                  held_r[in_note[IDX_W-1:0]] <= 1'b1;
                  state_r <= S_RD;
                end
              end
              dtss_pkg::CMD_NOTE_OFF: begin
                if (note_ok) begin
                  held_r[in_note[IDX_W-1:0]] <= 1'b0;
                  state_r <= S_FIND1;
                end
              end
              dtss_pkg::CMD_BEND: begin
                state_r <= S_FIND1;
              end
              dtss_pkg::CMD_SET_POTS: begin
                pot_a_r <= pa_cl;
                pot_m_r <= pb_cl;
                state_r <= S_MUL0;
              end
              default: begin
                // Table load writes the RAM directly; unused codes do nothing.
              end
            endcase
          end else if (recalc_pend_r) begin
            // A write in this same cycle keeps the request standing for another pass.
            if (!cfg_we) begin
              recalc_pend_r <= 1'b0;
            end
            state_r <= S_MUL0;
          end
        end
        S_TICK: begin
          if (out_free) begin
            ac_r         <= ac_nxt;
            mc_r         <= mc_nxt;
            lvl_r        <= lvl_nxt;
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {(dtss_pkg::OUT_TDATA_W - dtss_pkg::SAMPLE_W - 2)'(0),
                             snd, lvl_nxt, sample_nxt};
            state_r      <= S_IDLE;
          end
        end
        S_FIND1: begin
          state_r <= S_FIND2;
        end
        S_FIND2: begin
          state_r <= S_RD;
        end
        S_RD: begin
          // Note on always reads its own entry; the others need a held note.
          if (cmd_r == dtss_pkg::CMD_NOTE_ON || low.any) begin
            state_r <= S_USE;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_USE: begin
          if (cmd_r == dtss_pkg::CMD_BEND) begin
            c_r     <= rd_b;
            prod_r  <= mul_out;
            state_r <= S_BADD;
          end else begin
            pot_a_r <= rd_a;
            pot_m_r <= rd_b;
            state_r <= S_MUL0;
          end
        end
        S_BADD: begin
          pot_m_r <= bend_neg ? (c_r + bend_shifted) : bend_shifted;
          state_r <= S_MUL0;
        end
        S_MUL0: begin
          prod_r  <= mul_out;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod_r  <= mul_out;
          ah_r    <= thr_sat;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_out;
          al_r    <= thr_sat;
          state_r <= S_FIN;
        end
        S_FIN: begin
          mh_r     <= thr_sat;
          period_r <= {1'b0, ah_r} + {1'b0, al_r};
          state_r  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        recalc_pend_r <= 1'b1;
        unique case (dtss_pkg::cfg_idx_t'(cfg_index))
          dtss_pkg::CFG_ASTABLE_SCALE: astable_scale_r <= cfg_wdata;
          dtss_pkg::CFG_MONO_SCALE:    mono_scale_r    <= cfg_wdata;
          dtss_pkg::CFG_AMPLITUDE:     amplitude_r     <= cfg_wdata[dtss_pkg::AMP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A tick that finds the output register free always delivers its result.
  a_tick_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && out_free) |=> out_tvalid)
    else $error("tick did not produce a result");

  // The held bitmap only changes when an item is accepted.
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(held_r))
    else $error("held notes changed without an accepted item");

  // Silence gives a zero sample.
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[17]) |-> (out_tdata[15:0] == '0))
    else $error("silent result with non-zero sample");

  // A non-zero sample carries the sign of the square level.
  a_sign_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15:0] != '0) |-> (out_tdata[15] == !out_tdata[16]))
    else $error("sample sign does not match level");

endmodule
